// ----- hw/rtl/ebpa_pkg.sv -----
package ebpa_pkg;

  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 17;
  localparam int STAT_W  = 3;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EXT_FREE   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_PAGE_FREE  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD        = 3'd4;

  localparam logic [1:0] ES_FREE = 2'd1;
  localparam logic [1:0] ES_FRAG = 2'd2;
  localparam logic [1:0] ES_FULL = 2'd3;

  localparam logic [1:0] L_FREE = 2'd0;
  localparam logic [1:0] L_FRAG = 2'd1;
  localparam logic [1:0] L_FULL = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;

  typedef struct packed {
    logic              action;
    logic [PAGE_W-1:0] page_number;
  } in_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  allocated_page;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] fragment_pages_used;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LK_Q,
    S_LK_OFF,
    S_LK_CHK,
    S_LK_FIN,
    S_DISPATCH,
    S_F_FULL2,
    S_F_CHKALL,
    S_F_TOFREE,
    S_A_POSTFILL,
    S_A_TAKE,
    S_A_TOFRAG,
    S_A_RD,
    S_A_FIND,
    S_A_CHK,
    S_A_TOFULL,
    S_FILL,
    S_PUSH1,
    S_PUSH2,
    S_UNL0,
    S_UNL1,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/extent_bitmap_page_allocator.sv -----
// Page allocator over extents of EXTENT_PAGES pages, with per-extent free bitmaps
// and free, free-fragment and full-fragment extent lists held in simple dual-port
// synchronous memories (one read and one write per cycle each). One transaction is
// handled at a time: a page lookup steps through the quotient, offset, check and
// finish states, each list move is an unlink, a state update and a push, and each
// extent created in a batch is written and then pushed, with one closing fill step
// per batch. The sequencer runs these dependent memory read-modify-write steps in
// turn. A finished result waits in the output register while the next transaction
// is accepted; a stalled output holds the sequencer only when a second result is
// ready. The space size register may be written only while no transaction is in
// flight.
module extent_bitmap_page_allocator
  import ebpa_pkg::*;
#(
  parameter int EXTENT_PAGES           = 64,
  parameter int MAX_EXTENTS            = 1024,
  parameter int DESCRIPTOR_GROUP_PAGES = 16384,
  parameter int FILL_BATCH             = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  localparam int EXTW = $clog2(MAX_EXTENTS + 1);
  localparam int AW   = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int OFFW = $clog2(EXTENT_PAGES);
  localparam int FCW  = $clog2(FILL_BATCH + 1);
  localparam longint unsigned RECIP = ((64'd1 << 24) + EXTENT_PAGES - 1) / EXTENT_PAGES;
  localparam longint unsigned MAX_PAGES = longint'(MAX_EXTENTS) * EXTENT_PAGES;
  localparam logic [EXTW-1:0] NIL = EXTW'(MAX_EXTENTS);
  localparam logic [EXTENT_PAGES-1:0] MASK = {EXTENT_PAGES{1'b1}};

  function automatic logic [OFFW:0] find_free(input logic [EXTENT_PAGES-1:0] bm,
                                              input logic [OFFW-1:0] start);
    logic hit_hi;
    logic hit_any;
    logic [OFFW-1:0] p_hi;
    logic [OFFW-1:0] p_any;
    hit_hi  = 1'b0;
    hit_any = 1'b0;
    p_hi    = '0;
    p_any   = '0;
    for (int k = EXTENT_PAGES - 1; k >= 0; k--) begin
      if (bm[k]) begin
        hit_any = 1'b1;
        p_any   = OFFW'(k);
        if (k >= int'(start)) begin
          hit_hi = 1'b1;
          p_hi   = OFFW'(k);
        end
      end
    end
    return hit_hi ? {1'b1, p_hi} : {hit_any, p_any};
  endfunction

  state_t state_r, state_nxt;
  state_t ret_push_r, ret_push_nxt;
  state_t ret_unl_r, ret_unl_nxt;
  state_t ret_fill_r, ret_fill_nxt;

  logic [COUNT_W-1:0] space_r;
  logic               act_r, act_nxt;
  logic [PAGE_W-1:0]  pg_r, pg_nxt;
  logic [15:0]        q_r, q_nxt;
  logic [COUNT_W-1:0] base_r, base_nxt;
  logic [OFFW-1:0]    off_r, off_nxt;
  logic               lk_ok_r, lk_ok_nxt;
  logic [EXTW-1:0]    e_r, e_nxt;
  logic [EXTW-1:0]    pe_r, pe_nxt;
  logic [1:0]         l_r, l_nxt;
  logic [OFFW-1:0]    pos_r, pos_nxt;
  logic [EXTENT_PAGES-1:0] bm_cur_r, bm_cur_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [PAGE_W-1:0]  pg_res_r, pg_res_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] fl_r, fl_nxt;
  logic [EXTW-1:0]    fl_ext_r, fl_ext_nxt;
  logic [COUNT_W-1:0] grp_r, grp_nxt;
  logic [FCW-1:0]     fcnt_r, fcnt_nxt;
  logic [EXTW-1:0]    head_r [3];
  logic [EXTW-1:0]    head_nxt [3];
  logic [EXTW-1:0]    tail_r [3];
  logic [EXTW-1:0]    tail_nxt [3];
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic [EXTENT_PAGES-1:0] bm_mem [MAX_EXTENTS];
  logic [1:0]              st_mem [MAX_EXTENTS];
  logic [EXTW-1:0]         nx_mem [MAX_EXTENTS];
  logic [EXTW-1:0]         pv_mem [MAX_EXTENTS];
  logic [EXTENT_PAGES-1:0] bm_q;
  logic [1:0]              st_q;
  logic [EXTW-1:0]         nx_q;
  logic [EXTW-1:0]         pv_q;

  logic [AW-1:0]           mem_ra;
  logic                    bm_we, st_we, nx_we, pv_we;
  logic [AW-1:0]           bm_wa, st_wa, nx_wa, pv_wa;
  logic [EXTENT_PAGES-1:0] bm_wd;
  logic [1:0]              st_wd;
  logic [EXTW-1:0]         nx_wd, pv_wd;

  logic [COUNT_W-1:0] eff;
  logic [39:0]        prod;
  logic [31:0]        qmul;
  logic [31:0]        page_mul;
  logic               range_bad;
  logic               pg_eq_fl;
  logic               fill_more;
  logic               grp_start;
  logic [COUNT_W:0]   grp_sum;
  logic [OFFW:0]      ff;
  logic [EXTENT_PAGES-1:0] bit_sel;
  logic               can_load;

  assign eff       = (64'(space_r) < MAX_PAGES) ? space_r : COUNT_W'(MAX_PAGES);
  assign prod      = 40'(pg_r) * 40'(RECIP);
  assign qmul      = 32'(q_r) * 32'(EXTENT_PAGES);
  assign page_mul  = 32'(e_r) * 32'(EXTENT_PAGES) + 32'(pos_r);
  assign range_bad = ({1'b0, pg_r} >= eff) || ({1'b0, pg_r} > fl_r);
  assign pg_eq_fl  = ({1'b0, pg_r} == fl_r);
  assign fill_more = ((18'(fl_r) + 18'(EXTENT_PAGES)) <= 18'(eff)) &&
                     (32'(fcnt_r) < 32'(FILL_BATCH));
  assign grp_start = (grp_r == '0);
  assign grp_sum   = 18'(grp_r) + 18'(EXTENT_PAGES);
  assign ff        = find_free(bm_q, off_r);
  assign bit_sel   = EXTENT_PAGES'(1) << off_r;
  assign can_load  = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_q <= bm_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_q <= st_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_q <= nx_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_q <= pv_mem[mem_ra];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_LK_Q;
      S_LK_Q:     state_nxt = S_LK_OFF;
      S_LK_OFF:   state_nxt = S_LK_CHK;
      S_LK_CHK: begin
        if (range_bad) state_nxt = S_DISPATCH;
        else if (pg_eq_fl) state_nxt = S_FILL;
        else state_nxt = S_LK_FIN;
      end
      S_LK_FIN:   state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (act_r != ACT_ALLOC) begin
          if (!lk_ok_r || st_q == ES_FREE || (st_q != ES_FRAG && st_q != ES_FULL) ||
              (bm_q & bit_sel) != '0) state_nxt = S_DONE;
          else if (st_q == ES_FULL) state_nxt = S_UNL0;
          else state_nxt = S_F_CHKALL;
        end else begin
          if (lk_ok_r && st_q == ES_FRAG) state_nxt = S_A_RD;
          else if (head_r[L_FRAG] != NIL) state_nxt = S_A_RD;
          else if (lk_ok_r && st_q == ES_FREE) state_nxt = S_A_TAKE;
          else if (head_r[L_FREE] == NIL) state_nxt = S_FILL;
          else state_nxt = S_A_POSTFILL;
        end
      end
      S_F_FULL2:    state_nxt = S_PUSH1;
      S_F_CHKALL:   state_nxt = (bm_cur_r == MASK) ? S_UNL0 : S_DONE;
      S_F_TOFREE:   state_nxt = S_PUSH1;
      S_A_POSTFILL: state_nxt = (head_r[L_FREE] == NIL) ? S_DONE : S_A_TAKE;
      S_A_TAKE:     state_nxt = S_UNL0;
      S_A_TOFRAG:   state_nxt = S_PUSH1;
      S_A_RD:       state_nxt = S_A_FIND;
      S_A_FIND:     state_nxt = ff[OFFW] ? S_A_CHK : S_DONE;
      S_A_CHK:      state_nxt = (bm_cur_r == '0) ? S_UNL0 : S_DONE;
      S_A_TOFULL:   state_nxt = S_PUSH1;
      S_FILL:       state_nxt = fill_more ? S_PUSH1 : ret_fill_r;
      S_PUSH1:      state_nxt = S_PUSH2;
      S_PUSH2:      state_nxt = ret_push_r;
      S_UNL0:       state_nxt = S_UNL1;
      S_UNL1:       state_nxt = ret_unl_r;
      S_DONE:       if (can_load) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    act_nxt      = act_r;
    pg_nxt       = pg_r;
    q_nxt        = q_r;
    base_nxt     = base_r;
    off_nxt      = off_r;
    lk_ok_nxt    = lk_ok_r;
    e_nxt        = e_r;
    pe_nxt       = pe_r;
    l_nxt        = l_r;
    pos_nxt      = pos_r;
    bm_cur_nxt   = bm_cur_r;
    status_nxt   = status_r;
    pg_res_nxt   = pg_res_r;
    cnt_nxt      = cnt_r;
    fl_nxt       = fl_r;
    fl_ext_nxt   = fl_ext_r;
    grp_nxt      = grp_r;
    fcnt_nxt     = fcnt_r;
    ret_push_nxt = ret_push_r;
    ret_unl_nxt  = ret_unl_r;
    ret_fill_nxt = ret_fill_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_ra = AW'(e_r);
    bm_we = 1'b0; bm_wa = AW'(e_r); bm_wd = bm_cur_r;
    st_we = 1'b0; st_wa = AW'(e_r); st_wd = ES_FRAG;
    nx_we = 1'b0; nx_wa = AW'(pe_r); nx_wd = NIL;
    pv_we = 1'b0; pv_wa = AW'(pe_r); pv_wd = NIL;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_data.action;
          pg_nxt  = in_data.page_number;
        end
      end
      S_LK_Q: q_nxt = prod[39:24];
      S_LK_OFF: begin
        base_nxt = qmul[COUNT_W-1:0];
        off_nxt  = OFFW'(32'(pg_r) - qmul);
      end
      S_LK_CHK: begin
        lk_ok_nxt    = 1'b0;
        ret_fill_nxt = S_LK_FIN;
      end
      S_LK_FIN: begin
        lk_ok_nxt = (base_r < fl_r);
        mem_ra    = AW'(q_r);
      end
      S_DISPATCH: begin
        status_nxt = STAT_OK;
        pg_res_nxt = '0;
        if (act_r != ACT_ALLOC) begin
          e_nxt = EXTW'(q_r);
          if (!lk_ok_r) status_nxt = STAT_BAD;
          else if (st_q == ES_FREE) status_nxt = STAT_EXT_FREE;
          else if (st_q != ES_FRAG && st_q != ES_FULL) status_nxt = STAT_BAD;
          else if ((bm_q & bit_sel) != '0) status_nxt = STAT_PAGE_FREE;
          else begin
            bm_we      = 1'b1;
            bm_wa      = AW'(q_r);
            bm_wd      = bm_q | bit_sel;
            bm_cur_nxt = bm_q | bit_sel;
            if (st_q == ES_FULL) begin
              pe_nxt      = EXTW'(q_r);
              l_nxt       = L_FULL;
              ret_unl_nxt = S_F_FULL2;
            end else if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
        end else begin
          if (lk_ok_r && st_q == ES_FRAG) begin
            e_nxt = EXTW'(q_r);
          end else begin
            off_nxt = '0;
            if (head_r[L_FRAG] != NIL) e_nxt = head_r[L_FRAG];
            else if (lk_ok_r && st_q == ES_FREE) e_nxt = EXTW'(q_r);
            else ret_fill_nxt = S_A_POSTFILL;
          end
        end
      end
      S_F_FULL2: begin
        st_we        = 1'b1;
        st_wd        = ES_FRAG;
        cnt_nxt      = cnt_r + COUNT_W'(EXTENT_PAGES - 1);
        pe_nxt       = e_r;
        l_nxt        = L_FRAG;
        ret_push_nxt = S_F_CHKALL;
      end
      S_F_CHKALL: begin
        pe_nxt      = e_r;
        l_nxt       = L_FRAG;
        ret_unl_nxt = S_F_TOFREE;
      end
      S_F_TOFREE: begin
        bm_we        = 1'b1;
        bm_wd        = MASK;
        st_we        = 1'b1;
        st_wd        = ES_FREE;
        pe_nxt       = e_r;
        l_nxt        = L_FREE;
        ret_push_nxt = S_DONE;
      end
      S_A_POSTFILL: begin
        e_nxt = head_r[L_FREE];
        if (head_r[L_FREE] == NIL) status_nxt = STAT_NO_SPACE;
      end
      S_A_TAKE: begin
        pe_nxt      = e_r;
        l_nxt       = L_FREE;
        ret_unl_nxt = S_A_TOFRAG;
      end
      S_A_TOFRAG: begin
        st_we        = 1'b1;
        st_wd        = ES_FRAG;
        pe_nxt       = e_r;
        l_nxt        = L_FRAG;
        ret_push_nxt = S_A_RD;
      end
      S_A_RD: mem_ra = AW'(e_r);
      S_A_FIND: begin
        if (!ff[OFFW]) begin
          status_nxt = STAT_NO_SPACE;
        end else begin
          pos_nxt    = ff[OFFW-1:0];
          bm_we      = 1'b1;
          bm_wd      = bm_q & ~(EXTENT_PAGES'(1) << ff[OFFW-1:0]);
          bm_cur_nxt = bm_q & ~(EXTENT_PAGES'(1) << ff[OFFW-1:0]);
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      S_A_CHK: begin
        pg_res_nxt  = page_mul[PAGE_W-1:0];
        pe_nxt      = e_r;
        l_nxt       = L_FRAG;
        ret_unl_nxt = S_A_TOFULL;
      end
      S_A_TOFULL: begin
        st_we        = 1'b1;
        st_wd        = ES_FULL;
        cnt_nxt      = (cnt_r >= COUNT_W'(EXTENT_PAGES)) ?
                       cnt_r - COUNT_W'(EXTENT_PAGES) : '0;
        pe_nxt       = e_r;
        l_nxt        = L_FULL;
        ret_push_nxt = S_DONE;
      end
      S_FILL: begin
        if (fill_more) begin
          bm_we        = 1'b1;
          bm_wa        = AW'(fl_ext_r);
          bm_wd        = grp_start ? (MASK & ~EXTENT_PAGES'(3)) : MASK;
          st_we        = 1'b1;
          st_wa        = AW'(fl_ext_r);
          st_wd        = grp_start ? ES_FRAG : ES_FREE;
          pe_nxt       = fl_ext_r;
          l_nxt        = grp_start ? L_FRAG : L_FREE;
          ret_push_nxt = S_FILL;
          fl_nxt       = fl_r + COUNT_W'(EXTENT_PAGES);
          fl_ext_nxt   = fl_ext_r + 1'b1;
          grp_nxt      = (grp_sum >= 18'(DESCRIPTOR_GROUP_PAGES)) ?
                         COUNT_W'(grp_sum - 18'(DESCRIPTOR_GROUP_PAGES)) :
                         COUNT_W'(grp_sum);
          if (grp_start) cnt_nxt = cnt_r + COUNT_W'(2);
          else fcnt_nxt = fcnt_r + 1'b1;
        end else begin
          fcnt_nxt = '0;
        end
      end
      S_PUSH1: begin
        nx_we = 1'b1;
        nx_wa = AW'(pe_r);
        nx_wd = NIL;
        pv_we = 1'b1;
        pv_wa = AW'(pe_r);
        pv_wd = tail_r[l_r];
      end
      S_PUSH2: begin
        if (tail_r[l_r] == NIL) begin
          head_nxt[l_r] = pe_r;
        end else begin
          nx_we = 1'b1;
          nx_wa = AW'(tail_r[l_r]);
          nx_wd = pe_r;
        end
        tail_nxt[l_r] = pe_r;
      end
      S_UNL0: mem_ra = AW'(pe_r);
      S_UNL1: begin
        if (pv_q == NIL) begin
          head_nxt[l_r] = nx_q;
        end else begin
          nx_we = 1'b1;
          nx_wa = AW'(pv_q);
          nx_wd = nx_q;
        end
        if (nx_q == NIL) begin
          tail_nxt[l_r] = pv_q;
        end else begin
          pv_we = 1'b1;
          pv_wa = AW'(nx_q);
          pv_wd = pv_q;
        end
      end
      S_DONE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.allocated_page      = (status_r == STAT_OK) ? pg_res_r : '0;
          out_data_nxt.status              = status_r;
          out_data_nxt.fragment_pages_used = cnt_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_push_r  <= S_IDLE;
      ret_unl_r   <= S_IDLE;
      ret_fill_r  <= S_IDLE;
      space_r     <= '0;
      cnt_r       <= '0;
      fl_r        <= '0;
      fl_ext_r    <= '0;
      grp_r       <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        head_r[i] <= NIL;
        tail_r[i] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      ret_push_r  <= ret_push_nxt;
      ret_unl_r   <= ret_unl_nxt;
      ret_fill_r  <= ret_fill_nxt;
      if (cfg_valid) space_r <= cfg_data;
      cnt_r       <= cnt_nxt;
      fl_r        <= fl_nxt;
      fl_ext_r    <= fl_ext_nxt;
      grp_r       <= grp_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    pg_r       <= pg_nxt;
    q_r        <= q_nxt;
    base_r     <= base_nxt;
    off_r      <= off_nxt;
    lk_ok_r    <= lk_ok_nxt;
    e_r        <= e_nxt;
    pe_r       <= pe_nxt;
    l_r        <= l_nxt;
    pos_r      <= pos_nxt;
    bm_cur_r   <= bm_cur_nxt;
    status_r   <= status_nxt;
    pg_res_r   <= pg_res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- hw/rtl/ebpa_checker.sv -----
module ebpa_checker
  import ebpa_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input in_t                in_data,
  input logic               out_valid,
  input logic               out_ready,
  input out_t               out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [COUNT_W-1:0] cfg_data
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while another is in flight");

  a_page_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.allocated_page == '0)
    else $error("page reported on a failed or free transaction");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= STAT_BAD)
    else $error("status code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind extent_bitmap_page_allocator ebpa_checker u_ebpa_checker (.*);

// ----- test/extent_bitmap_page_allocator_test.sv -----
module extent_bitmap_page_allocator_test;
  import ebpa_pkg::*;

  localparam int EXT_PAGES   = 64;
  localparam int MAX_EXT     = 1024;
  localparam int GROUP_PAGES = 16384;
  localparam int BATCH       = 4;
  localparam int NIL         = MAX_EXT;
  localparam int MAX_PG      = MAX_EXT * EXT_PAGES;
  localparam logic [63:0] ALL_FREE = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  extent_bitmap_page_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator mirror
  int unsigned space_pages, limit_pg, frag_cnt;
  logic [63:0] bitmap [MAX_EXT];
  logic [1:0]  ext_st [MAX_EXT];
  int unsigned nxt [MAX_EXT];
  int unsigned prv [MAX_EXT];
  int unsigned head [3];
  int unsigned tail [3];

  in_t  pending_reqs [$];
  out_t expected_results [$];
  int errors = 0;
  int n_results = 0;
  int n_ok_alloc = 0;
  int n_err_stat = 0;
  bit in_quiet = 0;
  bit out_quiet = 0;

  function automatic void list_push(int l, int unsigned e);
    nxt[e] = NIL;
    prv[e] = tail[l];
    if (tail[l] >= NIL) head[l] = e;
    else nxt[tail[l]] = e;
    tail[l] = e;
  endfunction

  function automatic void list_unlink(int l, int unsigned e);
    int unsigned p, n;
    p = prv[e];
    n = nxt[e];
    if (p >= NIL) head[l] = n;
    else nxt[p] = n;
    if (n >= NIL) tail[l] = p;
    else prv[n] = p;
  endfunction

  function automatic int unsigned usable_size();
    return space_pages < MAX_PG ? space_pages : MAX_PG;
  endfunction

  function automatic void create_extents();
    int unsigned i, cnt, e;
    i = limit_pg;
    cnt = 0;
    while (i + EXT_PAGES <= usable_size() && cnt < BATCH) begin
      e = i / EXT_PAGES;
      limit_pg = i + EXT_PAGES;
      bitmap[e] = ALL_FREE;
      ext_st[e] = ES_FREE;
      if (i % GROUP_PAGES == 0) begin
        bitmap[e][1:0] = 2'b00;
        ext_st[e] = ES_FRAG;
        list_push(L_FRAG, e);
        frag_cnt += 2;
      end else begin
        list_push(L_FREE, e);
        cnt++;
      end
      i += EXT_PAGES;
    end
  endfunction

  // returns extent index or NIL when the page has no descriptor
  function automatic int unsigned find_extent(int unsigned pg);
    if (pg >= usable_size() || pg > limit_pg) return NIL;
    if (pg == limit_pg) create_extents();
    if ((pg / EXT_PAGES) * EXT_PAGES >= limit_pg) return NIL;
    return pg / EXT_PAGES;
  endfunction

  function automatic logic [STAT_W-1:0] alloc_page(int unsigned hint, output int unsigned pg);
    int unsigned e, off, pos, k;
    bit found;
    pg = 0;
    e = find_extent(hint);
    off = hint % EXT_PAGES;
    if (e == NIL || ext_st[e] != ES_FRAG) begin
      off = 0;
      if (head[L_FRAG] < NIL) e = head[L_FRAG];
      else begin
        e = find_extent(hint);
        if (e == NIL || ext_st[e] != ES_FREE) begin
          if (head[L_FREE] >= NIL) create_extents();
          e = head[L_FREE];
          if (e >= NIL) return STAT_NO_SPACE;
        end
        list_unlink(L_FREE, e);
        ext_st[e] = ES_FRAG;
        list_push(L_FRAG, e);
      end
    end
    found = 0;
    pos = 0;
    for (k = 0; k < EXT_PAGES; k++)
      if (!found && bitmap[e][(off + k) % EXT_PAGES]) begin
        found = 1;
        pos = (off + k) % EXT_PAGES;
      end
    if (!found) return STAT_NO_SPACE;
    bitmap[e][pos] = 1'b0;
    frag_cnt++;
    if (bitmap[e] == '0) begin
      list_unlink(L_FRAG, e);
      ext_st[e] = ES_FULL;
      list_push(L_FULL, e);
      frag_cnt = frag_cnt >= EXT_PAGES ? frag_cnt - EXT_PAGES : 0;
    end
    pg = e * EXT_PAGES + pos;
    return STAT_OK;
  endfunction

  function automatic logic [STAT_W-1:0] release_page(int unsigned pg);
    int unsigned e, pos;
    logic [1:0] st;
    e = find_extent(pg);
    pos = pg % EXT_PAGES;
    if (e == NIL) return STAT_BAD;
    st = ext_st[e];
    if (st == ES_FREE) return STAT_EXT_FREE;
    if (st != ES_FRAG && st != ES_FULL) return STAT_BAD;
    if (bitmap[e][pos]) return STAT_PAGE_FREE;
    bitmap[e][pos] = 1'b1;
    if (st == ES_FULL) begin
      list_unlink(L_FULL, e);
      ext_st[e] = ES_FRAG;
      list_push(L_FRAG, e);
      frag_cnt += EXT_PAGES - 1;
    end else if (frag_cnt > 0) begin
      frag_cnt--;
    end
    if (bitmap[e] == ALL_FREE) begin
      list_unlink(L_FRAG, e);
      ext_st[e] = ES_FREE;
      list_push(L_FREE, e);
    end
    return STAT_OK;
  endfunction

  function automatic out_t predict_result(in_t req);
    out_t r;
    int unsigned pg;
    pg = 0;
    if (req.action == ACT_ALLOC) r.status = alloc_page(req.page_number, pg);
    else r.status = release_page(req.page_number);
    if (r.status != STAT_OK) pg = 0;
    r.allocated_page = pg[15:0];
    r.fragment_pages_used = frag_cnt[16:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %0s: got %0d, expected %0d (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_result(in_data));
        void'(pending_reqs.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > (in_valid && in_ready ? 0 : 0) &&
            (in_quiet || $urandom_range(99) >= 30)) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          out_t want;
          want = expected_results.pop_front();
          if (out_data.allocated_page !== want.allocated_page)
            report_mismatch("allocated_page", out_data.allocated_page, want.allocated_page);
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.fragment_pages_used !== want.fragment_pages_used)
            report_mismatch("fragment_pages_used", out_data.fragment_pages_used,
                            want.fragment_pages_used);
          if (want.status == STAT_OK && out_data.allocated_page != 0) n_ok_alloc++;
          if (want.status != STAT_OK) n_err_stat++;
        end
        n_results++;
      end
      out_ready <= out_quiet || $urandom_range(99) >= 30;
    end
  end

  task automatic write_size(int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val[COUNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    space_pages = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic void add_req(logic act, int unsigned pg);
    in_t r;
    r.action = act;
    r.page_number = pg[15:0];
    pending_reqs.push_back(r);
  endfunction

  // allocates and frees at random pages up to span, plus some requests at any page
  task automatic random_phase(int n, int unsigned span);
    for (int i = 0; i < n; i++) begin
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 50) add_req(ACT_ALLOC, $urandom_range(span));
      else if (sel < 90) add_req(~ACT_ALLOC, $urandom_range(span));
      else add_req(1'($urandom_range(1)), $urandom_range(65535));
    end
    drain();
  endtask

  initial begin
    space_pages = 0;
    limit_pg = 0;
    frag_cnt = 0;
    for (int k = 0; k < 3; k++) begin
      head[k] = NIL;
      tail[k] = NIL;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // size zero: nothing can be created
    add_req(ACT_ALLOC, 0);
    add_req(~ACT_ALLOC, 0);
    add_req(ACT_ALLOC, 16'hFFFF);
    drain();
    write_size(320);
    add_req(~ACT_ALLOC, 0);
    add_req(ACT_ALLOC, 0);
    add_req(ACT_ALLOC, 5);
    add_req(ACT_ALLOC, 63);
    add_req(~ACT_ALLOC, 0);
    add_req(~ACT_ALLOC, 3);
    add_req(~ACT_ALLOC, 2);
    add_req(~ACT_ALLOC, 100);
    add_req(~ACT_ALLOC, 300);
    add_req(~ACT_ALLOC, 319);
    add_req(~ACT_ALLOC, 320);
    add_req(~ACT_ALLOC, 16'hFFFF);
    for (int i = 0; i < 70; i++) add_req(ACT_ALLOC, 70);
    add_req(~ACT_ALLOC, 64);
    add_req(~ACT_ALLOC, 64);
    add_req(ACT_ALLOC, 16'hFFFF);
    drain();
    random_phase(300, 330);
    write_size(1000);
    random_phase(300, 1100);
    in_quiet = 1;
    out_quiet = 1;
    random_phase(200, 1100);
    in_quiet = 0;
    out_quiet = 0;
    write_size(17'h1FFFF);
    random_phase(300, 2000);
    for (int i = 0; i < 60; i++) add_req(1'($urandom_range(1)), $urandom_range(65535));
    drain();
    write_size(65536);
    random_phase(400, 20000);
    write_size(16500);
    random_phase(300, 17000);
    $display("Covered %0d transactions over six space sizes: %0d pages given out, %0d refused",
             n_results, n_ok_alloc, n_err_stat);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
